// ===== src/mbrr_pkg.sv =====
package mbrr_pkg;

  localparam int unsigned FRAME_LEN   = 9;
  localparam int unsigned NUM_HELD    = 5;
  localparam int unsigned HELD_AW     = $clog2(NUM_HELD);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 31;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'd4;
  localparam logic [7:0]  DATA_COUNT      = 8'd4;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [31:0] FLOAT_INF_BITS  = 32'h7F80_0000;

  localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
  localparam logic [30:0] RST_VOLTAGE_LIMIT  = 31'h43C8_0000;
  localparam logic [30:0] RST_CURRENT_LIMIT  = 31'h42C8_0000;
  localparam logic [30:0] RST_POWER_LIMIT    = 31'h46C3_5000;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT    = 2'd3;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_ARM  = 1'b1;

  localparam logic [2:0] QTY_NONE      = 3'd0;
  localparam logic [2:0] QTY_VOLTAGE   = 3'd1;
  localparam logic [2:0] QTY_CURRENT   = 3'd2;
  localparam logic [2:0] QTY_POWER     = 3'd3;
  localparam logic [2:0] QTY_ENERGY    = 3'd4;
  localparam logic [2:0] QTY_RESETTABLE = 3'd5;

  typedef struct packed {
    logic        frame_valid;
    logic [2:0]  done_quantity;
    logic [31:0] raw_value;
  } frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic above_limit(input logic [31:0] v, input logic [30:0] lim);
    logic [31:0] l;
    l = {1'b0, lim};
    return !v[31] && (v <= FLOAT_INF_BITS) && (l <= FLOAT_INF_BITS) && (v > l);
  endfunction

endpackage

// ===== src/mbrr_in_if.sv =====
interface mbrr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic [2:0] quantity;

  modport source (output valid, func, rx_byte, quantity, input ready);
  modport sink   (input valid, func, rx_byte, quantity, output ready);
endinterface

// ===== src/mbrr_out_if.sv =====
interface mbrr_out_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [2:0]  done_quantity;
  logic [31:0] raw_value;
  logic        updated;
  logic [31:0] held_value;

  modport source (output valid, frame_valid, done_quantity, raw_value, updated, held_value,
                  input ready);
  modport sink   (input valid, frame_valid, done_quantity, raw_value, updated, held_value,
                  output ready);
endinterface

// ===== src/mbrr_ram.sv =====
module mbrr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/mbrr_frame.sv =====
module mbrr_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              func,
  input  logic [7:0]        rx_byte,
  input  logic [2:0]        quantity,
  input  logic [7:0]        device_address,
  output logic              complete,
  output mbrr_pkg::frame_t  frame
);

  logic [3:0]  byte_index;
  logic [15:0] running_crc;
  logic        header_good;
  logic [31:0] value_shift;
  logic [7:0]  crc_low_byte;
  logic [15:0] computed_crc;
  logic [2:0]  pending_quantity;
  logic [15:0] crc_next;
  logic        is_byte;
  logic        last_byte;
  logic        crc_match;

  assign is_byte   = accept && (func == mbrr_pkg::FUNC_BYTE);
  assign last_byte = (byte_index == 4'(mbrr_pkg::FRAME_LEN - 1));
  assign complete  = is_byte && last_byte;
  assign crc_next  = mbrr_pkg::crc_byte(running_crc, rx_byte);
  assign crc_match = (computed_crc == {rx_byte, crc_low_byte});

  always_comb begin
    frame.frame_valid   = header_good && crc_match;
    frame.done_quantity = pending_quantity;
    frame.raw_value     = (header_good && crc_match) ? value_shift : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      running_crc      <= mbrr_pkg::CRC_INIT;
      header_good      <= 1'b1;
      value_shift      <= '0;
      crc_low_byte     <= '0;
      computed_crc     <= '0;
      pending_quantity <= mbrr_pkg::QTY_NONE;
    end else if (accept && func == mbrr_pkg::FUNC_ARM) begin
      pending_quantity <= (quantity <= mbrr_pkg::QTY_RESETTABLE) ? quantity
                                                                  : mbrr_pkg::QTY_NONE;
    end else if (is_byte) begin
      if (last_byte) begin
        byte_index       <= '0;
        running_crc      <= mbrr_pkg::CRC_INIT;
        header_good      <= 1'b1;
        value_shift      <= '0;
        crc_low_byte     <= '0;
        computed_crc     <= '0;
        pending_quantity <= mbrr_pkg::QTY_NONE;
      end else begin
        byte_index <= byte_index + 4'd1;
        if (byte_index < 4'd7) begin
          running_crc <= crc_next;
        end
        case (byte_index)
          4'd0: if (rx_byte != device_address) header_good <= 1'b0;
          4'd1: if (rx_byte != mbrr_pkg::FUNC_READ_INPUT) header_good <= 1'b0;
          4'd2: if (rx_byte != mbrr_pkg::DATA_COUNT) header_good <= 1'b0;
          4'd3, 4'd4, 4'd5: value_shift <= {value_shift[23:0], rx_byte};
          4'd6: begin
            value_shift  <= {value_shift[23:0], rx_byte};
            computed_crc <= crc_next;
          end
          4'd7: crc_low_byte <= rx_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/modbus_rtu_reading_receiver_unit.sv =====
// Modbus RTU function-4 response receiver. One item (a received byte or an
// arm event naming the pending quantity) is taken per cycle. The ninth byte
// of a frame yields one result, registered in the s1 stage and then in the
// result register: the frame is checked (address, function, byte count,
// CRC-16 over the first seven bytes) and the held reading of the pending
// quantity, kept in a small RAM with a registered read, is replaced or kept.
// Throughput is one item per cycle while results drain; a stalled result
// output holds one result, and the input stalls once a second waits behind it.
module modbus_rtu_reading_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  mbrr_in_if.sink                       item,
  mbrr_out_if.source                    result,
  input  logic                          cfg_we,
  input  logic [mbrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbrr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = mbrr_pkg::HELD_AW;

  logic [7:0]  device_address;
  logic [30:0] voltage_limit_bits;
  logic [30:0] current_limit_bits;
  logic [30:0] power_limit_bits;

  logic              accept;
  logic              complete;
  mbrr_pkg::frame_t  frame;

  logic              keep;
  logic              upd;
  logic [AW-1:0]     addr;
  logic [mbrr_pkg::NUM_HELD-1:0] entry_valid;

  logic              s1_valid;
  mbrr_pkg::frame_t  s1_frame;
  logic              s1_upd;
  logic              s1_ent_valid;
  logic [AW-1:0]     s1_addr;
  logic              s1_move;

  logic [AW-1:0]     rd_addr;
  logic [31:0]       rd_data;
  logic [31:0]       held_next;

  assign s1_move    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_move;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address     <= mbrr_pkg::RST_DEVICE_ADDRESS;
      voltage_limit_bits <= mbrr_pkg::RST_VOLTAGE_LIMIT;
      current_limit_bits <= mbrr_pkg::RST_CURRENT_LIMIT;
      power_limit_bits   <= mbrr_pkg::RST_POWER_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mbrr_pkg::REG_DEVICE_ADDRESS: device_address     <= cfg_data[7:0];
        mbrr_pkg::REG_VOLTAGE_LIMIT:  voltage_limit_bits <= cfg_data;
        mbrr_pkg::REG_CURRENT_LIMIT:  current_limit_bits <= cfg_data;
        mbrr_pkg::REG_POWER_LIMIT:    power_limit_bits   <= cfg_data;
        default: ;
      endcase
    end
  end

  mbrr_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .func           (item.func),
    .rx_byte        (item.rx_byte),
    .quantity       (item.quantity),
    .device_address (device_address),
    .complete       (complete),
    .frame          (frame)
  );

  always_comb begin
    keep = (frame.raw_value[30:0] == 31'd0);
    case (frame.done_quantity)
      mbrr_pkg::QTY_VOLTAGE:
        if (mbrr_pkg::above_limit(frame.raw_value, voltage_limit_bits)) keep = 1'b1;
      mbrr_pkg::QTY_CURRENT:
        if (mbrr_pkg::above_limit(frame.raw_value, current_limit_bits)) keep = 1'b1;
      mbrr_pkg::QTY_POWER:
        if (mbrr_pkg::above_limit(frame.raw_value, power_limit_bits)) keep = 1'b1;
      default: ;
    endcase
    upd  = (frame.done_quantity != mbrr_pkg::QTY_NONE) && !keep;
    addr = (frame.done_quantity == mbrr_pkg::QTY_NONE) ? '0
                                                       : AW'(frame.done_quantity - 3'd1);
  end

  // re-read the stalled entry each cycle so the read data stays aligned
  assign rd_addr = complete ? addr : s1_addr;

  mbrr_ram #(
    .WIDTH (32),
    .DEPTH (mbrr_pkg::NUM_HELD)
  ) u_held_ram (
    .clk     (clk),
    .wr_en   (complete && upd),
    .wr_addr (addr),
    .wr_data (frame.raw_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (complete && upd) begin
        entry_valid[addr] <= 1'b1;
      end
      if (complete) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      s1_frame     <= frame;
      s1_upd       <= upd;
      s1_ent_valid <= entry_valid[addr];
      s1_addr      <= addr;
    end
  end

  always_comb begin
    if (s1_upd) begin
      held_next = s1_frame.raw_value;
    end else if (s1_frame.done_quantity == mbrr_pkg::QTY_NONE || !s1_ent_valid) begin
      held_next = 32'd0;
    end else begin
      held_next = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.frame_valid   <= s1_frame.frame_valid;
      result.done_quantity <= s1_frame.done_quantity;
      result.raw_value     <= s1_frame.raw_value;
      result.updated       <= s1_upd;
      result.held_value    <= held_next;
    end
  end

endmodule
